// ===== hdl/swmm_pkg.sv =====
// shared types and constants for the sliding window max/min block
// no dependencies
`default_nettype none

package swmm_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int WINDOW_MAX = 1024;
  localparam int PTR_W      = $clog2(WINDOW_MAX);
  localparam int POS_W      = PTR_W + 1;
  localparam int LEN_W      = 11;
  localparam int ENTRY_W    = SAMPLE_W + POS_W;

  localparam logic signed [SAMPLE_W-1:0] INT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef struct packed {
    logic accept;
    logic rd_back;
    logic drop_head;
    logic keep_front;
    logic drop_tail;
    logic finish;
  } swmm_cmd_t;

  typedef struct packed {
    logic empty;
    logic expired;
    logic smaller;
  } swmm_stat_t;

endpackage

`default_nettype wire

// ===== hdl/swmm_in_if.sv =====
// request channel: sample and last mark with valid/ready
// depends on swmm_pkg
`default_nettype none

interface swmm_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [swmm_pkg::SAMPLE_W-1:0] sample;
  logic                               last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/swmm_out_if.sv =====
// result channel: window maximum, running minimum and flags with valid/ready
// depends on swmm_pkg
`default_nettype none

interface swmm_out_if;
  logic                               valid;
  logic                               ready;
  logic                               window_full;
  logic signed [swmm_pkg::SAMPLE_W-1:0] window_max;
  logic signed [swmm_pkg::SAMPLE_W-1:0] min_of_maxima;
  logic                               pass_done;

  modport source (output valid, output window_full, output window_max,
                  output min_of_maxima, output pass_done, input ready);
  modport sink   (input valid, input window_full, input window_max,
                  input min_of_maxima, input pass_done, output ready);
endinterface

`default_nettype wire

// ===== hdl/swmm_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module swmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/swmm_ctrl.sv =====
// controller state machine: request handshake, deque walk sequencing, result valid
// depends on swmm_pkg
`default_nettype none

module swmm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire swmm_pkg::swmm_stat_t stat_i,
  output swmm_pkg::swmm_cmd_t       cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_EXP_RD   = 6'b000010,
    ST_EXP_CHK  = 6'b000100,
    ST_BACK_RD  = 6'b001000,
    ST_BACK_CHK = 6'b010000,
    ST_FIN      = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXP_RD;
        end
      end
      ST_EXP_RD: begin
        state_d = stat_i.empty ? ST_BACK_RD : ST_EXP_CHK;
      end
      ST_EXP_CHK: begin
        if (stat_i.expired) begin
          cmd_o.drop_head = 1'b1;
          state_d         = ST_EXP_RD;
        end else begin
          cmd_o.keep_front = 1'b1;
          state_d          = ST_BACK_RD;
        end
      end
      ST_BACK_RD: begin
        cmd_o.rd_back = 1'b1;
        state_d       = stat_i.empty ? ST_FIN : ST_BACK_CHK;
      end
      ST_BACK_CHK: begin
        if (stat_i.smaller) begin
          cmd_o.drop_tail = 1'b1;
          state_d         = ST_BACK_RD;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/swmm_dp.sv =====
// datapath: window length register, deque pointers in registers, deque entries in ram,
// running minimum and result registers; depends on swmm_pkg and swmm_ram
`default_nettype none

module swmm_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [swmm_pkg::LEN_W-1:0]           cfg_wdata_i,
  input  wire logic signed [swmm_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                                 last_i,
  input  wire swmm_pkg::swmm_cmd_t                  cmd_i,
  output swmm_pkg::swmm_stat_t                      stat_o,
  output logic                                      window_full_o,
  output logic signed [swmm_pkg::SAMPLE_W-1:0]      window_max_o,
  output logic signed [swmm_pkg::SAMPLE_W-1:0]      min_of_maxima_o,
  output logic                                      pass_done_o
);

  localparam int SW = swmm_pkg::SAMPLE_W;
  localparam int PW = swmm_pkg::PTR_W;
  localparam int QW = swmm_pkg::POS_W;
  localparam int LW = swmm_pkg::LEN_W;

  logic [LW-1:0]        wlen_q;
  logic [PW-1:0]        head_q, head_d;
  logic [LW-1:0]        count_q, count_d;
  logic [QW-1:0]        pos_q, pos_d;
  logic [LW-1:0]        filled_q, filled_d;
  logic signed [SW-1:0] rmin_q, rmin_d;

  logic signed [SW-1:0] sample_q;
  logic                 last_q;
  logic [LW-1:0]        len_q, len_d;
  logic signed [SW-1:0] front_q;

  logic [PW-1:0]        raddr, waddr;
  logic                 ram_we;
  logic [swmm_pkg::ENTRY_W-1:0] rdata;
  logic signed [SW-1:0] rd_val;
  logic [QW-1:0]        rd_pos, age;
  logic signed [SW-1:0] front_val, wmax;
  logic [LW-1:0]        filled_nxt;
  logic                 full;

  assign rd_val = rdata[swmm_pkg::ENTRY_W-1 -: SW];
  assign rd_pos = rdata[QW-1:0];
  assign age    = pos_q - rd_pos;

  assign stat_o.empty   = (count_q == '0);
  assign stat_o.expired = (LW'(age) >= len_q);
  assign stat_o.smaller = (rd_val < sample_q);

  assign raddr  = cmd_i.rd_back ? (head_q + count_q[PW-1:0] - PW'(1)) : head_q;
  assign waddr  = head_q + count_q[PW-1:0];
  assign ram_we = cmd_i.finish && (count_q < LW'(swmm_pkg::WINDOW_MAX));

  swmm_ram #(
    .WIDTH (swmm_pkg::ENTRY_W),
    .DEPTH (swmm_pkg::WINDOW_MAX)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i ({sample_q, pos_q}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    if (wlen_q == '0) begin
      len_d = LW'(1);
    end else if (wlen_q > LW'(swmm_pkg::WINDOW_MAX)) begin
      len_d = LW'(swmm_pkg::WINDOW_MAX);
    end else begin
      len_d = wlen_q;
    end
  end

  assign front_val  = (count_q == '0) ? sample_q : front_q;
  assign filled_nxt = (filled_q < len_q) ? (filled_q + LW'(1)) : len_q;
  assign full       = (filled_nxt == len_q);
  assign wmax       = full ? front_val : '0;

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    pos_d    = pos_q;
    filled_d = filled_q;
    rmin_d   = rmin_q;
    if (cmd_i.drop_head) begin
      head_d  = head_q + PW'(1);
      count_d = count_q - LW'(1);
    end
    if (cmd_i.drop_tail) begin
      count_d = count_q - LW'(1);
    end
    if (cmd_i.finish) begin
      if (last_q) begin
        head_d   = '0;
        count_d  = '0;
        pos_d    = '0;
        filled_d = '0;
        rmin_d   = swmm_pkg::INT_MAX;
      end else begin
        count_d  = ram_we ? (count_q + LW'(1)) : count_q;
        pos_d    = pos_q + QW'(1);
        filled_d = filled_nxt;
        if (full && (front_val < rmin_q)) begin
          rmin_d = front_val;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q   <= LW'(1);
      head_q   <= '0;
      count_q  <= '0;
      pos_q    <= '0;
      filled_q <= '0;
      rmin_q   <= swmm_pkg::INT_MAX;
    end else begin
      if (cfg_we_i) begin
        wlen_q <= cfg_wdata_i;
      end
      head_q   <= head_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
      filled_q <= filled_d;
      rmin_q   <= rmin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_i;
      last_q   <= last_i;
      len_q    <= len_d;
    end
    if (cmd_i.keep_front) begin
      front_q <= rd_val;
    end
    if (cmd_i.finish) begin
      window_full_o   <= full;
      window_max_o    <= wmax;
      min_of_maxima_o <= (full && (front_val < rmin_q)) ? front_val : rmin_q;
      pass_done_o     <= last_q;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sliding_window_max_min.sv =====
// timing: after a request is taken the controller expires old entries at the front, drops smaller
// entries at the back, then registers the result, waiting while a previous result is not yet taken
// flow: one request at a time; no new request is taken until its result is registered
// reset: asynchronous active low; deque empty, window length 1, running minimum at max
// depends on swmm_pkg, swmm_in_if, swmm_out_if, swmm_ctrl, swmm_dp
`default_nettype none

module sliding_window_max_min (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [swmm_pkg::LEN_W-1:0] cfg_wdata_i,
  swmm_in_if.sink                         req_i,
  swmm_out_if.source                      res_o
);

  swmm_pkg::swmm_cmd_t  cmd;
  swmm_pkg::swmm_stat_t stat;

  swmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  swmm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .sample_i        (req_i.sample),
    .last_i          (req_i.last),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .window_full_o   (res_o.window_full),
    .window_max_o    (res_o.window_max),
    .min_of_maxima_o (res_o.min_of_maxima),
    .pass_done_o     (res_o.pass_done)
  );

endmodule

`default_nettype wire

// ===== hdl/swmm_checker.sv =====
// port-level assertions for sliding_window_max_min, attached by bind
// depends on swmm_pkg
`default_nettype none

module swmm_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_valid_i,
  input wire logic                                 in_ready_i,
  input wire logic                                 out_valid_i,
  input wire logic                                 out_ready_i,
  input wire logic                                 window_full_i,
  input wire logic signed [swmm_pkg::SAMPLE_W-1:0] window_max_i,
  input wire logic signed [swmm_pkg::SAMPLE_W-1:0] min_of_maxima_i
);

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("request taken while previous one still in work");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped before taken");

  a_partial_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !window_full_i) |-> (window_max_i == '0))
    else $error("window max nonzero on partial window");

  a_min_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && window_full_i) |-> (min_of_maxima_i <= window_max_i))
    else $error("running minimum above current window max");

endmodule

bind sliding_window_max_min swmm_checker u_swmm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (req_i.valid),
  .in_ready_i      (req_i.ready),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .window_full_i   (res_o.window_full),
  .window_max_i    (res_o.window_max),
  .min_of_maxima_i (res_o.min_of_maxima)
);

`default_nettype wire

// ===== tb/swmm_checker.sv =====
`timescale 1ns / 100ps
// checker for the sliding window max/min block: watches config writes and both channels,
// keeps its own deque model and compares every result in order
// depends on swmm_pkg, swmm_in_if, swmm_out_if
module swmm_tb_checker
  import swmm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  swmm_in_if               req_i,
  swmm_out_if              res_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic                       window_full;
    logic signed [SAMPLE_W-1:0] window_max;
    logic signed [SAMPLE_W-1:0] min_of_maxima;
    logic                       pass_done;
  } max_min_t;

  logic signed [SAMPLE_W-1:0] cand_val [WINDOW_MAX];
  logic [POS_W-1:0]           cand_pos [WINDOW_MAX];
  logic [PTR_W-1:0]           cand_head;
  int                         cand_cnt;
  logic [POS_W-1:0]           cur_pos;
  int                         filled;
  logic signed [SAMPLE_W-1:0] low_max;
  logic [LEN_W-1:0]           win_len;

  max_min_t max_min_q[$];
  int       fail_count = 0;
  int       pending;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  task automatic clear_pass();
    cand_head = '0;
    cand_cnt  = 0;
    cur_pos   = '0;
    filled    = 0;
    low_max   = INT_MAX;
  endtask

  task automatic advance_window(input logic signed [SAMPLE_W-1:0] s, input logic lst,
                                output max_min_t r);
    int               len;
    int               idx;
    logic [POS_W-1:0] age;
    len = int'(win_len);
    if (len == 0) len = 1;
    if (len > WINDOW_MAX) len = WINDOW_MAX;
    // expire old candidates
    while (cand_cnt > 0) begin
      age = cur_pos - cand_pos[cand_head];
      if (int'(age) >= len) begin
        cand_head = cand_head + 1'b1;
        cand_cnt--;
      end else begin
        break;
      end
    end
    // drop smaller candidates from the back, equal ones stay
    while (cand_cnt > 0) begin
      idx = (int'(cand_head) + cand_cnt - 1) % WINDOW_MAX;
      if (cand_val[idx] < s) cand_cnt--;
      else break;
    end
    if (cand_cnt < WINDOW_MAX) begin
      idx = (int'(cand_head) + cand_cnt) % WINDOW_MAX;
      cand_val[idx] = s;
      cand_pos[idx] = cur_pos;
      cand_cnt++;
    end
    if (filled < len) filled++;
    if (filled > len) filled = len;
    r.window_full = (filled >= len);
    r.window_max  = '0;
    if (r.window_full) begin
      r.window_max = cand_val[cand_head];
      if (r.window_max < low_max) low_max = r.window_max;
    end
    r.min_of_maxima = low_max;
    r.pass_done     = lst;
    cur_pos = cur_pos + 1'b1;
    if (lst) clear_pass();
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint want);
    fail_count++;
    if (fail_count <= 50)
      $display("mismatch in %s: got %0d, expected %0d", field, got, want);
  endtask

  always @(posedge clk_i) begin : monitor
    max_min_t want;
    max_min_t got;
    if (!rst_ni) begin
      win_len = 1;
      clear_pass();
    end else begin
      if (cfg_we_i) win_len = cfg_wdata_i;
      if (req_i.valid && req_i.ready) begin
        advance_window(req_i.sample, req_i.last, want);
        max_min_q.insert(max_min_q.size(), want);
      end
      if (res_i.valid && res_i.ready) begin
        got.window_full   = res_i.window_full;
        got.window_max    = res_i.window_max;
        got.min_of_maxima = res_i.min_of_maxima;
        got.pass_done     = res_i.pass_done;
        if (max_min_q.size() == 0) begin
          report_mismatch("unexpected result, window_max", longint'($signed(got.window_max)), 0);
        end else begin
          want = max_min_q[0];
          max_min_q.delete(0);
          if (got.window_full !== want.window_full)
            report_mismatch("window_full", longint'(got.window_full),
                            longint'(want.window_full));
          if (got.window_max !== want.window_max)
            report_mismatch("window_max", longint'($signed(got.window_max)),
                            longint'($signed(want.window_max)));
          if (got.min_of_maxima !== want.min_of_maxima)
            report_mismatch("min_of_maxima", longint'($signed(got.min_of_maxima)),
                            longint'($signed(want.min_of_maxima)));
          if (got.pass_done !== want.pass_done)
            report_mismatch("pass_done", longint'(got.pass_done), longint'(want.pass_done));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pending <= 0;
    end else begin
      pending <= pending + int'(req_i.valid && req_i.ready) - int'(res_i.valid && res_i.ready);
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// top of the testbench: clock, reset, sample and window stimulus, result stalls and verdict
// depends on swmm_pkg, swmm_in_if, swmm_out_if, swmm_tb_checker, sliding_window_max_min
module tb;
  import swmm_pkg::*;

  typedef enum {DATA_RANDOM, DATA_NARROW, DATA_EXTREME, DATA_FALLING} data_mode_e;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SMALL_ITEMS    = 40;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  swmm_in_if  req_if ();
  swmm_out_if res_if ();

  int                         fail_count;
  int                         pending;
  int                         stall_cycles = 0;
  int                         sent = 0;
  bit                         burst = 1'b0;
  bit                         hold_go = 1'b0;
  logic signed [SAMPLE_W-1:0] fall_val = INT_MAX;

  always #2 clk = ~clk;

  sliding_window_max_min dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  swmm_tb_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .res_i       (res_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || cfg_we) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result side stalls, with one long hold-off while requests keep coming
  initial begin : result_stall
    bit held;
    int pick;
    int dur;
    logic lvl;
    held = 1'b0;
    res_if.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      pick = $urandom_range(0, 99);
      if (!held && hold_go) begin
        held = 1'b1;
        lvl  = 1'b0;
        dur  = HOLD_CYCLES;
      end else if (pick < 60) begin
        lvl = 1'b1;
        dur = 1;
      end else if (pick < 88) begin
        lvl = 1'b0;
        dur = $urandom_range(1, 3);
      end else if (pick < 96) begin
        lvl = 1'b1;
        dur = $urandom_range(20, 80);
      end else begin
        lvl = 1'b0;
        dur = $urandom_range(15, 60);
      end
      res_if.ready <= lvl;
      repeat (dur) @(posedge clk);
    end
  end

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (burst || pick < 65) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(data_mode_e mode);
    case (mode)
      DATA_NARROW:  return SAMPLE_W'(int'($urandom_range(0, 7)) - 4);
      DATA_EXTREME: begin
        case ($urandom_range(0, 5))
          0:       return SAMPLE_MIN;
          1:       return INT_MAX;
          2:       return '0;
          3:       return '1;
          4:       return SAMPLE_W'(1);
          default: return $urandom();
        endcase
      end
      DATA_FALLING: begin
        if (fall_val < SAMPLE_MIN + 8) fall_val = INT_MAX;
        else fall_val = fall_val - SAMPLE_W'($urandom_range(0, 3));
        return fall_val;
      end
      default:      return $urandom();
    endcase
  endfunction

  function automatic int pick_window_len();
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return 1;
      2:       return 2047;
      3:       return $urandom_range(1025, 2047);
      4, 5:    return $urandom_range(13, 64);
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.sample <= s;
    req_if.last   <= lst;
    do @(posedge clk); while (!req_if.ready);
    sent++;
  endtask

  // only while idle: no request offered and every result back
  task automatic set_window(input int len_val);
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= LEN_W'(len_val);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_pass(input int n, input data_mode_e mode, input bit split);
    int split_at;
    split_at = split ? $urandom_range(1, n - 1) : -1;
    fall_val = $urandom();
    for (int i = 0; i < n; i++) begin
      if (i == split_at) set_window(pick_window_len());
      send_sample(pick_sample(mode), i == n - 1);
    end
  endtask

  initial begin : stimulus
    int small_start;
    int w;
    int eff;
    int n;
    req_if.valid  = 1'b0;
    req_if.sample = '0;
    req_if.last   = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    do @(posedge clk); while (!rst_n);

    // window of one straight out of reset: extremes and equal samples
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(INT_MAX, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample('1, 1'b0);
    send_sample(SAMPLE_W'(1), 1'b1);
    // array shorter than the window
    set_window(3);
    send_sample(SAMPLE_W'(5), 1'b0);
    send_sample(SAMPLE_W'(5), 1'b1);
    // window shrinks in the middle of a pass
    send_sample(SAMPLE_W'(7), 1'b0);
    send_sample(SAMPLE_W'(7), 1'b0);
    send_sample(SAMPLE_W'(3), 1'b0);
    send_sample(SAMPLE_W'(9), 1'b0);
    send_sample(SAMPLE_W'(1), 1'b0);
    set_window(2);
    send_sample(SAMPLE_W'(4), 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_W'(6), 1'b1);
    // zero length acts as one
    set_window(0);
    send_sample(SAMPLE_W'(-3), 1'b0);
    send_sample(INT_MAX, 1'b1);
    // length beyond the deque size, pass too short to fill
    set_window(2047);
    send_sample(SAMPLE_W'(100), 1'b0);
    send_sample(SAMPLE_W'(-100), 1'b0);
    send_sample('0, 1'b1);

    // full size window with a non-increasing run that fills the deque,
    // then a shrink that expires most of it
    set_window(1024);
    burst    = 1'b1;
    fall_val = INT_MAX - SAMPLE_W'($urandom_range(0, 1000));
    for (int i = 0; i < 1030; i++) begin
      if (i == 200) hold_go = 1'b1;
      send_sample(pick_sample(i < 1026 ? DATA_FALLING : DATA_RANDOM), 1'b0);
    end
    burst = 1'b0;
    set_window($urandom_range(1, 8));
    for (int i = 0; i < 10; i++) send_sample(pick_sample(DATA_EXTREME), i == 9);

    small_start = sent;
    while (sent - small_start < SMALL_ITEMS) begin
      w = pick_window_len();
      set_window(w);
      eff   = (w == 0) ? 1 : ((w > WINDOW_MAX) ? WINDOW_MAX : w);
      burst = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 4)) begin
        if (eff > 64) n = $urandom_range(1, 24);
        else if (eff > 1 && $urandom_range(0, 4) == 0) n = $urandom_range(1, eff - 1);
        else n = $urandom_range(eff, 3 * eff + 6);
        run_pass(n, data_mode_e'($urandom_range(0, 3)), n > 2 && $urandom_range(0, 3) == 0);
      end
    end

    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
